### hw/rtl/gbnf_pkg.sv
package gbnf_pkg;

  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int NCOUNT_W  = 3;
  localparam int S_DATA_W  = 104;
  localparam int M_DATA_W  = 56;
  localparam int M_USED_W  = NCOUNT_W + 8 * IDX_W;

  typedef logic [1:0] req_t;
  localparam req_t REQ_WRITE_X = 2'd0;
  localparam req_t REQ_WRITE_Y = 2'd1;
  localparam req_t REQ_QUERY   = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_X_COUNT = 1'b0;
  localparam cfg_idx_t REG_Y_COUNT = 1'b1;

  localparam logic [NCOUNT_W-1:0] NB_ONE  = 3'd1;
  localparam logic [NCOUNT_W-1:0] NB_TWO  = 3'd2;
  localparam logic [NCOUNT_W-1:0] NB_FOUR = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_ENDS,
    ST_EVAL_ENDS,
    ST_READ_MID,
    ST_EVAL_MID
  } state_t;

  typedef struct packed {
    logic wr_x;
    logic wr_y;
    logic latch_q;
    logic eval_ends;
    logic rd_mid;
    logic eval_mid;
    logic load_out;
  } cmd_t;

endpackage

### hw/rtl/gbnf_axis.sv
module gbnf_axis
  import gbnf_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic signed [VAL_W-1:0] wr_value,
  input  logic signed [VAL_W-1:0] query,
  input  logic [COUNT_W-1:0]     count,
  input  cmd_t                   cmd,
  output logic                   done,
  output logic                   at_edge,
  output logic [$clog2(GRID_MAX)-1:0] lo
);

  localparam int IW = $clog2(GRID_MAX);

  logic signed [COORD_WIDTH-1:0] mem [GRID_MAX];
  logic signed [COORD_WIDTH-1:0] rdata_a;
  logic signed [COORD_WIDTH-1:0] rdata_b;
  logic signed [COORD_WIDTH-1:0] q;
  logic [IW-1:0] top;
  logic [IW-1:0] hi;
  logic [IW-1:0] mid;
  logic [IW-1:0] addr_a;
  logic [IW-1:0] top_next;
  logic [IW-1:0] lo_step;
  logic [IW-1:0] hi_step;
  logic          asc;
  logic          go_up;
  logic          below;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) < GRID_MAX)) begin
      mem[IW'(wr_idx)] <= COORD_WIDTH'(wr_value);
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[top];
  end

  assign mid    = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign addr_a = cmd.rd_mid ? mid : '0;

  always_comb begin
    if (count == '0) begin
      top_next = '0;
    end else if (32'(count) > GRID_MAX) begin
      top_next = IW'(GRID_MAX - 1);
    end else begin
      top_next = IW'(count - 7'd1);
    end
  end

  // A step moves towards larger indices when the comparison agrees with the grid's order.
  assign go_up   = ((q >= rdata_a) == asc);
  assign lo_step = go_up ? mid : lo;
  assign hi_step = go_up ? hi : mid;

  always_ff @(posedge clk) begin
    if (cmd.latch_q) begin
      q   <= COORD_WIDTH'(query);
      top <= top_next;
    end
    if (cmd.eval_ends) begin
      if (q > rdata_b) begin
        lo    <= top;
        below <= 1'b0;
        done  <= 1'b1;
      end else if (q < rdata_a) begin
        lo    <= '0;
        below <= 1'b1;
        done  <= 1'b1;
      end else begin
        asc   <= (rdata_b >= rdata_a);
        lo    <= '0;
        hi    <= top;
        below <= 1'b0;
        done  <= (top <= IW'(1));
      end
    end
    if (cmd.eval_mid && !done) begin
      lo   <= lo_step;
      hi   <= hi_step;
      done <= ((hi_step - lo_step) <= IW'(1));
    end
  end

  assign at_edge = below || (lo == top);

endmodule

### hw/rtl/gbnf_datapath.sv
module gbnf_datapath
  import gbnf_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                rst,
  input  logic                clk,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic [S_DATA_W-1:0] in_data,
  input  cmd_t                cmd,
  output logic                search_done,
  output logic [M_DATA_W-1:0] out_data
);

  localparam int IW = $clog2(GRID_MAX);

  logic [COUNT_W-1:0] x_count;
  logic [COUNT_W-1:0] y_count;
  logic [IDX_W-1:0]   entry_index;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [VAL_W-1:0] query_x;
  logic signed [VAL_W-1:0] query_y;
  logic          x_done, y_done;
  logic          x_edge, y_edge;
  logic [IW-1:0] x_lo, y_lo;
  logic [IW-1:0] x_up, y_up;
  logic [NCOUNT_W-1:0] nb_count;
  logic [IW-1:0] xa, ya, xb, yb, xc, yc, xd, yd;

  assign entry_index = in_data[IDX_W-1:0];
  assign entry_value = in_data[IDX_W +: VAL_W];
  assign query_x     = in_data[IDX_W + VAL_W +: VAL_W];
  assign query_y     = in_data[IDX_W + 2 * VAL_W +: VAL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= 7'd2;
      y_count <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_COUNT: x_count <= cfg_data;
        REG_Y_COUNT: y_count <= cfg_data;
        default: ;
      endcase
    end
  end

  gbnf_axis #(.GRID_MAX(GRID_MAX), .COORD_WIDTH(COORD_WIDTH)) u_x_axis (
    .clk      (clk),
    .wr_en    (cmd.wr_x),
    .wr_idx   (entry_index),
    .wr_value (entry_value),
    .query    (query_x),
    .count    (x_count),
    .cmd      (cmd),
    .done     (x_done),
    .at_edge  (x_edge),
    .lo       (x_lo)
  );

  gbnf_axis #(.GRID_MAX(GRID_MAX), .COORD_WIDTH(COORD_WIDTH)) u_y_axis (
    .clk      (clk),
    .wr_en    (cmd.wr_y),
    .wr_idx   (entry_index),
    .wr_value (entry_value),
    .query    (query_y),
    .count    (y_count),
    .cmd      (cmd),
    .done     (y_done),
    .at_edge  (y_edge),
    .lo       (y_lo)
  );

  assign search_done = x_done && y_done;
  assign x_up = x_lo + IW'(1);
  assign y_up = y_lo + IW'(1);

  // An axis below its grid already reports index zero, so edges need no further clamping.
  always_comb begin
    {xa, ya, xb, yb, xc, yc, xd, yd} = '0;
    if (!x_edge && !y_edge) begin
      nb_count = NB_FOUR;
      xa = x_lo; ya = y_lo;
      xb = x_lo; yb = y_up;
      xc = x_up; yc = y_lo;
      xd = x_up; yd = y_up;
    end else if (x_edge && !y_edge) begin
      nb_count = NB_TWO;
      xa = x_lo; ya = y_lo;
      xb = x_lo; yb = y_up;
    end else if (!x_edge && y_edge) begin
      nb_count = NB_TWO;
      xa = x_lo; ya = y_lo;
      xb = x_up; yb = y_lo;
    end else begin
      nb_count = NB_ONE;
      xa = x_lo; ya = y_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {(M_DATA_W - M_USED_W)'(0),
                   IDX_W'(yd), IDX_W'(xd), IDX_W'(yc), IDX_W'(xc),
                   IDX_W'(yb), IDX_W'(xb), IDX_W'(ya), IDX_W'(xa), nb_count};
    end
  end

endmodule

### hw/rtl/gbnf_ctrl.sv
module gbnf_ctrl
  import gbnf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  req_t req_type,
  input  logic out_ready,
  input  logic search_done,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_type)
            REQ_WRITE_X: cmd.wr_x = 1'b1;
            REQ_WRITE_Y: cmd.wr_y = 1'b1;
            REQ_QUERY: begin
              cmd.latch_q = 1'b1;
              state_next  = ST_READ_ENDS;
            end
            default: ;
          endcase
        end
      end
      ST_READ_ENDS: state_next = ST_EVAL_ENDS;
      ST_EVAL_ENDS: begin
        cmd.eval_ends = 1'b1;
        state_next    = ST_READ_MID;
      end
      ST_READ_MID: begin
        if (!search_done) begin
          cmd.rd_mid = 1'b1;
          state_next = ST_EVAL_MID;
        end else if (slot_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_EVAL_MID: begin
        cmd.eval_mid = 1'b1;
        state_next   = ST_READ_MID;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/grid_bracket_neighbour_finder_unit.sv
// Grid bracket neighbour finder.
// Input stream (s_axis_*): one request per transfer. tuser carries the request
// kind: write an x grid entry, write a y grid entry, or query a point. A
// query locates both axes by bisection in parallel and delivers one result
// on the output stream (m_axis_*) giving 4, 2 or 1 bracketing (x,y) index
// pairs; unused pairs are zero.
// Each axis takes at most ceil(log2(count-1)) bisection steps, six for a
// 64-entry grid, and the search runs until both axes are done. Each step
// is a grid memory read followed by a compare, which sets the rate; a new
// request is taken in the cycle after the result is registered.
// The grid counts are written on the cfg_* port; the user must write them only
// while no query is in flight, as the block does not enforce this.
// Reset sets both counts to 2 and empties the output register; grid contents
// are undefined until written.
// The result sits in an output register: while the receiver stalls, further
// grid writes are still taken, and a finished query waits until the register
// is free.
module grid_bracket_neighbour_finder_unit
  import gbnf_pkg::*;
#(
  parameter int GRID_MAX    = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index, entry_value, query_x, query_y
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // neighbour_count, x_index_a, y_index_a, x_index_b, y_index_b,
  // x_index_c, y_index_c, x_index_d, y_index_d
  output logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [COUNT_W-1:0]  cfg_data
);

  cmd_t cmd;
  logic search_done;

  gbnf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .req_type    (s_axis_tuser),
    .out_ready   (m_axis_tready),
    .search_done (search_done),
    .in_ready    (s_axis_tready),
    .out_valid   (m_axis_tvalid),
    .cmd         (cmd)
  );

  gbnf_datapath #(.GRID_MAX(GRID_MAX), .COORD_WIDTH(COORD_WIDTH)) u_datapath (
    .rst         (rst),
    .clk         (clk),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_data     (s_axis_tdata),
    .cmd         (cmd),
    .search_done (search_done),
    .out_data    (m_axis_tdata)
  );

endmodule

### hw/rtl/gbnf_checker.sv
module gbnf_checker
  import gbnf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [1:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  // A stalled result must hold.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result visible after reset");

  // A query keeps the input side closed while the search runs.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_QUERY) |=> !s_axis_tready)
    else $error("request taken during search");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[NCOUNT_W-1:0] == NB_ONE) ||
                      (m_axis_tdata[NCOUNT_W-1:0] == NB_TWO) ||
                      (m_axis_tdata[NCOUNT_W-1:0] == NB_FOUR))
    else $error("bad neighbour count");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[NCOUNT_W-1:0] == NB_ONE) |->
      (m_axis_tdata[M_DATA_W-1:NCOUNT_W + 2 * IDX_W] == '0))
    else $error("unused pairs not zero");

endmodule

bind grid_bracket_neighbour_finder_unit gbnf_checker u_gbnf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
